/* hdl/fm_register_stream_latch_fixer_unit_assert.svh */
// Assertion shorthands for the latch fixer checker.
`ifndef FM_REGISTER_STREAM_LATCH_FIXER_UNIT_ASSERT_SVH
`define FM_REGISTER_STREAM_LATCH_FIXER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FMLF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FMLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/fmlf_pkg.sv */
`default_nettype none

package fmlf_pkg;

    // PCM buffer
    localparam int PCM_DEPTH = 2048;
    localparam int PCM_AW    = $clog2(PCM_DEPTH);
    localparam int PCM_CW    = $clog2(PCM_DEPTH + 1);
    localparam int IDX_W     = 11;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Command codes
    localparam logic [7:0] CODE_WAIT = 8'd0;
    localparam logic [7:0] CODE_FM0  = 8'd1;
    localparam logic [7:0] CODE_FM1  = 8'd2;
    localparam logic [7:0] CODE_TONE = 8'd3;

    // Result kinds
    localparam logic [1:0] KIND_FM   = 2'd0;
    localparam logic [1:0] KIND_TONE = 2'd1;
    localparam logic [1:0] KIND_PCM  = 2'd2;

    // Register numbers and masks
    localparam logic [7:0] REG_PCM   = 8'h2A;
    localparam logic [7:0] FREQ_MASK = 8'hF0;
    localparam logic [7:0] FREQ_BASE = 8'hA0;
    localparam logic [7:0] PAIR_BIT  = 8'h04;

    typedef struct packed {
        logic [1:0]       kind;
        logic             port;
        logic [7:0]       reg_num;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] pcm_index;
        logic             pcm_dropped;
        logic             last;
    } result_t;

    // One command's worth of words: one or two results.
    typedef struct packed {
        result_t res0;
        result_t res1;
        logic    two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

/* hdl/fm_register_stream_latch_fixer_unit.sv */
// Channel  Dir  tdata (low bit up)                                    tuser      tlast
// s_axis   in   arg_reg[7:0] arg_data[15:8] next_valid[16]            req_type   -
//               next_code[24:17] next_reg[32:25] seeking[33] 0[39:34]
// m_axis   out  port[0] reg_num[8:1] data_byte[16:9] pcm_index[27:17]  kind       last
//               pcm_dropped[28] 0[31:29]
//
// A command is taken every cycle while the four-entry command queue has room;
// the front updates the frequency cache, latches and PCM counters in that cycle.
// Results leave the output register one word a cycle unless m_axis stalls, so a command
// with two writes gives two words; each word passes the queue, then the output register.
// Reset (aresetn low, synchronous) clears cache, latches and counters at once.
// A stall on m_axis fills the queue, then drops s_axis_tready.
`default_nettype none

module fm_register_stream_latch_fixer_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // arg_reg, arg_data, next_valid, next_code, next_reg, seeking, zero pad
    input  wire logic [fmlf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  wire logic [fmlf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // port, reg_num, data_byte, pcm_index, pcm_dropped, zero pad
    output logic [fmlf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [fmlf_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast
);
    import fmlf_pkg::*;

    q_stat_t q_stat;
    entry_t  push_entry;
    entry_t  q_head;
    logic    q_push;
    logic    q_pop;
    result_t m_result;

    // Classify the command and update the latch state.
    fmlf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .req_type   (s_axis_tuser),
        .arg_reg    (s_axis_tdata[7:0]),
        .arg_data   (s_axis_tdata[15:8]),
        .next_valid (s_axis_tdata[16]),
        .next_code  (s_axis_tdata[24:17]),
        .next_reg   (s_axis_tdata[32:25]),
        .seeking    (s_axis_tdata[33]),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    // Hold up to four commands' worth of writes.
    fmlf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // Drain each entry one word at a time.
    fmlf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {3'b000, m_result.pcm_dropped, m_result.pcm_index,
                           m_result.data_byte, m_result.reg_num, m_result.port};
    assign m_axis_tuser = m_result.kind;
    assign m_axis_tlast = m_result.last;

endmodule

`default_nettype wire

/* hdl/fmlf_front.sv */
`default_nettype none

module fmlf_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        req_type,
    input  wire logic [7:0]        arg_reg,
    input  wire logic [7:0]        arg_data,
    input  wire logic              next_valid,
    input  wire logic [7:0]        next_code,
    input  wire logic [7:0]        next_reg,
    input  wire logic              seeking,
    input  wire fmlf_pkg::q_stat_t q_stat,
    output logic                   q_push,
    output fmlf_pkg::entry_t       q_entry
);
    import fmlf_pkg::*;

    function automatic result_t mk_fm(input logic p, input logic [7:0] r,
                                      input logic [7:0] d, input logic lst);
        result_t w;
        w             = '0;
        w.kind        = KIND_FM;
        w.port        = p;
        w.reg_num     = r;
        w.data_byte   = d;
        w.last        = lst;
        return w;
    endfunction

    logic [7:0]        cache_reg [32];
    logic [7:0]        latch_reg [2];
    logic [7:0]        latch_next [2];
    logic [31:0]       frame_count_reg, frame_count_next;
    logic [31:0]       pcm_frame_reg, pcm_frame_next;
    logic [PCM_CW-1:0] pcm_count_reg, pcm_count_next;
    logic [7:0]        pcm_store [PCM_DEPTH];

    logic              accept;
    logic              port;
    logic              is_pcm;
    logic              is_freq;
    logic [4:0]        slot;
    logic [4:0]        pair;
    logic              lid;
    logic [7:0]        pair_byte;
    logic [7:0]        pair_reg;
    logic              paired;
    logic              new_frame;
    logic [PCM_CW-1:0] base_count;
    logic              pcm_full;
    logic              cache_we;
    logic              pcm_we;

    assign s_ready    = !q_stat.full;
    assign accept     = s_valid && s_ready;
    assign port       = (req_type == CODE_FM1);
    assign is_pcm     = !port && (arg_reg == REG_PCM);
    assign is_freq    = (arg_reg & FREQ_MASK) == FREQ_BASE;
    assign slot       = {port, arg_reg[3:0]};
    assign pair       = {port, arg_reg[3], ~arg_reg[2], arg_reg[1:0]};
    assign lid        = arg_reg[3];
    assign pair_byte  = cache_reg[pair];
    assign pair_reg   = arg_reg ^ PAIR_BIT;
    assign paired     = next_valid && (next_code == req_type) && (next_reg == pair_reg);
    assign new_frame  = pcm_frame_reg != frame_count_reg;
    assign base_count = new_frame ? '0 : pcm_count_reg;
    assign pcm_full   = base_count == PCM_CW'(PCM_DEPTH);

    always_comb begin
        q_push           = 1'b0;
        q_entry          = '0;
        latch_next       = latch_reg;
        frame_count_next = frame_count_reg;
        pcm_frame_next   = pcm_frame_reg;
        pcm_count_next   = pcm_count_reg;
        cache_we         = 1'b0;
        pcm_we           = 1'b0;
        if (accept) begin
            case (req_type)
                CODE_WAIT: begin
                    frame_count_next = frame_count_reg + 32'd1;
                end
                CODE_TONE: begin
                    q_push                  = 1'b1;
                    q_entry.res0.kind       = KIND_TONE;
                    q_entry.res0.data_byte  = arg_reg;
                    q_entry.res0.last       = 1'b1;
                end
                CODE_FM0, CODE_FM1: begin
                    if (is_pcm) begin
                        if (!seeking) begin
                            q_push                 = 1'b1;
                            pcm_frame_next         = frame_count_reg;
                            q_entry.res0.kind      = KIND_PCM;
                            q_entry.res0.data_byte = arg_data;
                            q_entry.res0.last      = 1'b1;
                            if (pcm_full) begin
                                q_entry.res0.pcm_dropped = 1'b1;
                                pcm_count_next           = base_count;
                            end else begin
                                pcm_we                 = 1'b1;
                                q_entry.res0.pcm_index = IDX_W'(base_count);
                                pcm_count_next         = base_count + PCM_CW'(1);
                            end
                        end
                    end else if (is_freq) begin
                        q_push   = 1'b1;
                        cache_we = 1'b1;
                        if (arg_reg[2]) begin
                            // high part: patch in the cached low part unless it follows
                            latch_next[lid] = arg_data;
                            q_entry.res0    = mk_fm(port, arg_reg, arg_data, paired);
                            q_entry.res1    = mk_fm(port, pair_reg, pair_byte, 1'b1);
                            q_entry.two     = !paired;
                        end else if (latch_reg[lid] != pair_byte) begin
                            // stale latch: resend the cached high part first
                            latch_next[lid] = pair_byte;
                            q_entry.res0    = mk_fm(port, pair_reg, pair_byte, 1'b0);
                            q_entry.res1    = mk_fm(port, arg_reg, arg_data, 1'b1);
                            q_entry.two     = 1'b1;
                        end else begin
                            q_entry.res0 = mk_fm(port, arg_reg, arg_data, 1'b1);
                        end
                    end else begin
                        q_push       = 1'b1;
                        q_entry.res0 = mk_fm(port, arg_reg, arg_data, 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) begin
                cache_reg[i] <= '0;
            end
            latch_reg[0]    <= '0;
            latch_reg[1]    <= '0;
            frame_count_reg <= '0;
            pcm_frame_reg   <= '1;
            pcm_count_reg   <= '0;
        end else begin
            if (cache_we) begin
                cache_reg[slot] <= arg_data;
            end
            latch_reg       <= latch_next;
            frame_count_reg <= frame_count_next;
            pcm_frame_reg   <= pcm_frame_next;
            pcm_count_reg   <= pcm_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pcm_we) begin
            pcm_store[base_count[PCM_AW-1:0]] <= arg_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/fmlf_queue.sv */
`default_nettype none

module fmlf_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire fmlf_pkg::entry_t push_entry,
    input  wire logic             pop,
    output fmlf_pkg::entry_t      head,
    output fmlf_pkg::q_stat_t     stat
);
    import fmlf_pkg::*;

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign head       = slots_reg[rd_ptr_reg];
    assign stat.full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (QUEUE_AW+1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/fmlf_back.sv */
`default_nettype none

module fmlf_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fmlf_pkg::q_stat_t q_stat,
    input  wire fmlf_pkg::entry_t  q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fmlf_pkg::result_t      m_result
);
    import fmlf_pkg::*;

    logic    valid_reg, valid_next;
    logic    phase_reg, phase_next;
    result_t out_reg;
    logic    load;

    // Load the output word when it is empty or being taken.
    assign load     = !q_stat.empty && (!valid_reg || m_ready);
    assign q_pop    = load && (phase_reg || !q_head.two);
    assign m_valid  = valid_reg;
    assign m_result = out_reg;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load) begin
            valid_next = 1'b1;
            phase_next = !phase_reg && q_head.two;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= phase_reg ? q_head.res1 : q_head.res0;
        end
    end

endmodule

`default_nettype wire

/* hdl/fmlf_checker.sv */
`default_nettype none
`include "fm_register_stream_latch_fixer_unit_assert.svh"

module fmlf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import fmlf_pkg::*;

    `FMLF_ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "m_axis_tvalid dropped while stalled")
    `FMLF_ASSERT_NEXT(a_data_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "m_axis_tdata changed while stalled")
    `FMLF_ASSERT_SAME(a_single_last, aclk, aresetn, m_axis_tvalid && (m_axis_tuser != KIND_FM), m_axis_tlast, "tone or pcm word without last")
    `FMLF_ASSERT_SAME(a_non_fm_clear, aclk, aresetn, m_axis_tvalid && (m_axis_tuser != KIND_FM), m_axis_tdata[8:0] == 9'd0, "tone or pcm word carries port or register")

endmodule

bind fm_register_stream_latch_fixer_unit fmlf_checker u_fmlf_checker (.*);

`default_nettype wire
